/* hw/rtl/tpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants, types and register codes of the touch point conditioner.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int unsigned RAW_W  = 12;
	localparam int unsigned PT_W   = 13;
	localparam int unsigned PRES_W = 13;
	localparam int unsigned CAP_W  = 16;
	localparam int unsigned STAT_W = 8;

	localparam int unsigned SCREEN_W = 240;
	localparam int unsigned SCREEN_H = 320;

	localparam int unsigned RAW_FULL = 4095;
	localparam int unsigned RAW_X_LO = 200;
	localparam int unsigned RAW_X_HI = 3700;
	localparam int unsigned RAW_Y_LO = 200;
	localparam int unsigned RAW_Y_HI = 3750;

	localparam int unsigned X_GAIN = SCREEN_W - 1;
	localparam int unsigned Y_GAIN = SCREEN_H - 1;
	localparam int unsigned X_SPAN = RAW_X_HI - RAW_X_LO;
	localparam int unsigned Y_SPAN = RAW_Y_HI - RAW_Y_LO;

	localparam int unsigned SCREEN_MAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
	localparam int unsigned GAIN_W     = $clog2(SCREEN_MAX);
	// Width of the scaled numerator, also used for the quotient.
	localparam int unsigned NUM_W      = RAW_W + GAIN_W;

	localparam int unsigned THRESH_RESET = 300;

	localparam logic [STAT_W-1:0] STATUS_NONE = 8'h00;
	localparam logic [STAT_W-1:0] STATUS_ALL  = 8'hFF;

	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_TOUCH_KIND = 2'd0,
		REG_THRESHOLD  = 2'd1,
		REG_LANDSCAPE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              touch_kind;
		logic [PRES_W-1:0] pressure_threshold;
		logic              landscape;
	} cfg_t;

	// Per-stage load enables handed to the divider lanes.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} div_en_t;

	// Item data that rides alongside the divider lanes.
	typedef struct packed {
		logic              kind;
		logic              down;
		logic [RAW_W-1:0]  cap_x;
		logic [RAW_W-1:0]  cap_y;
		logic [PRES_W-1:0] pressure;
	} side_t;

endpackage

/* hw/rtl/touch_point_conditioner_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_point_conditioner_core
// Throughput: one sample beat per cycle unless the result stream stalls;
// five register stages with a valid bit each, and a stage loads whenever
// it is empty or the next one moves on.
// Reset clears all valid bits, the last pressure to zero and the registers to
// capacitive mode, threshold 300 and portrait orientation.
// ----------------------------------------------------------------------------
module touch_point_conditioner_core import tpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Sample stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0 up: cap_status[7:0], cap_x_word[23:8],
	// cap_y_word[39:24], z_one[51:40], z_two[63:52], x_first[75:64],
	// x_second[87:76], x_third[99:88], y_first[111:100],
	// y_second[123:112], y_third[135:124].
	input  logic [135:0]          s_axis_tdata,
	// Result stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0 up: point_x[12:0], point_y[25:13],
	// pressure[38:26], zero fill [39].
	output logic [39:0]           m_axis_tdata,
	// Fields from bit 0 up: pressed[0].
	output logic                  m_axis_tuser,
	// Configuration bus.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t cfg;

	tpc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Unpack the incoming beat.
	logic [STAT_W-1:0] cap_status;
	logic [CAP_W-1:0]  cap_x_word;
	logic [CAP_W-1:0]  cap_y_word;
	logic [RAW_W-1:0]  z_one;
	logic [RAW_W-1:0]  z_two;
	logic [RAW_W-1:0]  x_first;
	logic [RAW_W-1:0]  x_second;
	logic [RAW_W-1:0]  x_third;
	logic [RAW_W-1:0]  y_first;
	logic [RAW_W-1:0]  y_second;
	logic [RAW_W-1:0]  y_third;

	assign cap_status = s_axis_tdata[7:0];
	assign cap_x_word = s_axis_tdata[23:8];
	assign cap_y_word = s_axis_tdata[39:24];
	assign z_one      = s_axis_tdata[51:40];
	assign z_two      = s_axis_tdata[63:52];
	assign x_first    = s_axis_tdata[75:64];
	assign x_second   = s_axis_tdata[87:76];
	assign x_third    = s_axis_tdata[99:88];
	assign y_first    = s_axis_tdata[111:100];
	assign y_second   = s_axis_tdata[123:112];
	assign y_third    = s_axis_tdata[135:124];

	// Stage handshake. Each stage takes new data when it is empty or when
	// the stage after it is taking its contents, so bubbles are squeezed
	// out even while the output beat waits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic in_acc;

	assign rdy5          = !v_s5 || m_axis_tready;
	assign rdy4          = !v_s4 || rdy5;
	assign rdy3          = !v_s3 || rdy4;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: pressure, press decision and the closest-pair averages.
	// The pressure register moves only on resistive beats, in beat order,
	// so each beat carries the value the stream had at its own point.
	logic [PRES_W-1:0] last_pressure_q;
	logic [PRES_W-1:0] new_pressure;
	logic              cap_down;
	logic [RAW_W-1:0]  rx;
	logic [RAW_W-1:0]  ry;
	side_t             side_in;

	assign new_pressure = PRES_W'(z_one) + PRES_W'(RAW_FULL) - PRES_W'(z_two);

	always_comb begin
		cap_down = !(cap_status inside {STATUS_NONE, STATUS_ALL});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pressure_q <= '0;
		end else if (in_acc && cfg.touch_kind) begin
			last_pressure_q <= new_pressure;
		end
	end

	tpc_pick u_pick_x (.a(x_first), .b(x_second), .c(x_third), .avg(rx));
	tpc_pick u_pick_y (.a(y_first), .b(y_second), .c(y_third), .avg(ry));

	always_comb begin
		side_in.kind     = cfg.touch_kind;
		side_in.cap_x    = cap_x_word[RAW_W-1:0];
		side_in.cap_y    = cap_y_word[RAW_W-1:0];
		if (cfg.touch_kind) begin
			side_in.down     = new_pressure >= cfg.pressure_threshold;
			side_in.pressure = new_pressure;
		end else begin
			side_in.down     = cap_down;
			side_in.pressure = last_pressure_q;
		end
	end

	side_t            side_s1, side_s2, side_s3, side_s4;
	logic [RAW_W-1:0] rx_s1;
	logic [RAW_W-1:0] ry_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1 <= side_in;
			rx_s1   <= rx;
			ry_s1   <= ry;
		end
		if (rdy2) side_s2 <= side_s1;
		if (rdy3) side_s3 <= side_s2;
		if (rdy4) side_s4 <= side_s3;
	end

	// Stages 2 to 4: scale each axis against its calibration span.
	div_en_t          div_en;
	logic [NUM_W-1:0] qx;
	logic [NUM_W-1:0] qy;
	logic             negx;
	logic             negy;

	assign div_en.s2 = rdy2;
	assign div_en.s3 = rdy3;
	assign div_en.s4 = rdy4;

	tpc_axis_div #(
		.RAW_LO (RAW_X_LO),
		.GAIN   (X_GAIN),
		.SPAN   (X_SPAN)
	) u_div_x (
		.clk  (clk),
		.en   (div_en),
		.raw  (rx_s1),
		.quot (qx),
		.neg  (negx)
	);

	tpc_axis_div #(
		.RAW_LO (RAW_Y_LO),
		.GAIN   (Y_GAIN),
		.SPAN   (Y_SPAN)
	) u_div_y (
		.clk  (clk),
		.en   (div_en),
		.raw  (ry_s1),
		.quot (qy),
		.neg  (negy)
	);

	// Stage 5: clamp, mirror for landscape, zero the point on release.
	// X runs from the right edge down: below the low calibration point it
	// pins at the right edge and past the span it pins at zero. Y runs
	// upward and pins at zero and at the bottom edge.
	logic [RAW_W-1:0] mx;
	logic [RAW_W-1:0] my;
	logic [RAW_W-1:0] x12;
	logic [RAW_W-1:0] y12;
	logic [PT_W-1:0]  px;
	logic [PT_W-1:0]  py;

	always_comb begin
		if (negx) begin
			mx = RAW_W'(X_GAIN);
		end else if (qx >= NUM_W'(X_GAIN)) begin
			mx = '0;
		end else begin
			mx = RAW_W'(NUM_W'(X_GAIN) - qx);
		end

		if (negy) begin
			my = '0;
		end else if (qy >= NUM_W'(Y_GAIN)) begin
			my = RAW_W'(Y_GAIN);
		end else begin
			my = RAW_W'(qy);
		end

		x12 = side_s4.kind ? mx : side_s4.cap_x;
		y12 = side_s4.kind ? my : side_s4.cap_y;

		if (!side_s4.down) begin
			px = '0;
			py = '0;
		end else if (cfg.landscape) begin
			px = PT_W'(SCREEN_W) - PT_W'(x12);
			py = PT_W'(SCREEN_H) - PT_W'(y12);
		end else begin
			px = PT_W'(x12);
			py = PT_W'(y12);
		end
	end

	logic              pressed_s5;
	logic              kind_s5;
	logic [PT_W-1:0]   px_s5;
	logic [PT_W-1:0]   py_s5;
	logic [PRES_W-1:0] pres_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			pressed_s5 <= side_s4.down;
			kind_s5    <= side_s4.kind;
			px_s5      <= px;
			py_s5      <= py;
			pres_s5    <= side_s4.pressure;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tuser  = pressed_s5;
	assign m_axis_tdata  = {1'b0, pres_s5, py_s5, px_s5};

	// A released beat never carries a point.
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !pressed_s5) |-> (px_s5 == '0 && py_s5 == '0))
		else $error("released beat with nonzero point");

	// A resistive press in portrait lands on the screen.
	a_res_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && kind_s5 && pressed_s5 && !cfg.landscape) |->
		(px_s5 < PT_W'(SCREEN_W) && py_s5 < PT_W'(SCREEN_H)))
		else $error("resistive point outside the screen");

	// An empty first stage never blocks the sample stream.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stalled with empty first stage");

	// The pressure register moves only on a taken resistive beat.
	a_pres_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && cfg.touch_kind) |=> $stable(last_pressure_q))
		else $error("pressure changed without a resistive beat");

endmodule

/* hw/rtl/tpc_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pick
// Floored average of the two closest of three samples.
// ----------------------------------------------------------------------------
module tpc_pick import tpc_pkg::*; (
	input  logic [RAW_W-1:0] a,
	input  logic [RAW_W-1:0] b,
	input  logic [RAW_W-1:0] c,
	output logic [RAW_W-1:0] avg
);

	logic [RAW_W-1:0] dab;
	logic [RAW_W-1:0] dbc;
	logic [RAW_W-1:0] dca;
	logic [RAW_W:0]   sum;

	assign dab = (a > b) ? a - b : b - a;
	assign dbc = (b > c) ? b - c : c - b;
	assign dca = (c > a) ? c - a : a - c;

	// Ties go to the first/second pair, then second/third.
	always_comb begin
		if (dab <= dbc && dab <= dca) begin
			sum = {1'b0, a} + {1'b0, b};
		end else if (dbc <= dab && dbc <= dca) begin
			sum = {1'b0, b} + {1'b0, c};
		end else begin
			sum = {1'b0, a} + {1'b0, c};
		end
	end

	assign avg = sum[RAW_W:1];

endmodule

/* hw/rtl/tpc_axis_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_axis_div
// Three-stage lane: (raw - lo) * gain, then division by span through a
// reciprocal multiply and a one-step correction.
// ----------------------------------------------------------------------------
module tpc_axis_div import tpc_pkg::*; #(
	parameter int unsigned RAW_LO = RAW_X_LO,
	parameter int unsigned GAIN   = X_GAIN,
	parameter int unsigned SPAN   = X_SPAN
) (
	input  logic             clk,
	input  div_en_t          en,
	input  logic [RAW_W-1:0] raw,
	output logic [NUM_W-1:0] quot,
	output logic             neg
);

	localparam int unsigned RECIP   = (2 ** NUM_W) / SPAN;
	localparam int unsigned RECIP_W = $clog2(RECIP + 1);
	localparam int unsigned PROD_W  = NUM_W + RECIP_W;

	logic [RAW_W-1:0]  mag;
	logic [NUM_W-1:0]  num_s2;
	logic              neg_s2;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0]  num_s3;
	logic [NUM_W-1:0]  q0_s3;
	logic              neg_s3;
	logic [NUM_W-1:0]  rem;
	logic [NUM_W-1:0]  quot_s4;
	logic              neg_s4;

	// Below the low calibration point the mapped value only clamps.
	assign mag = (raw < RAW_W'(RAW_LO)) ? '0 : raw - RAW_W'(RAW_LO);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_s2 <= NUM_W'(mag) * NUM_W'(GAIN);
			neg_s2 <= raw < RAW_W'(RAW_LO);
		end
	end

	// The estimate is the true quotient or one less, since num < 2**NUM_W.
	assign prod = PROD_W'(num_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q0_s3  <= NUM_W'(prod >> NUM_W);
			num_s3 <= num_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign rem = num_s3 - NUM_W'(q0_s3 * NUM_W'(SPAN));

	always_ff @(posedge clk) begin
		if (en.s4) begin
			quot_s4 <= q0_s3 + NUM_W'(rem >= NUM_W'(SPAN));
			neg_s4  <= neg_s3;
		end
	end

	assign quot = quot_s4;
	assign neg  = neg_s4;

endmodule

/* hw/rtl/tpc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_cfg_regs
// Register file behind the configuration bus.
// ----------------------------------------------------------------------------
module tpc_cfg_regs import tpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_kind         <= 1'b0;
			cfg_q.pressure_threshold <= PRES_W'(THRESH_RESET);
			cfg_q.landscape          <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_TOUCH_KIND: cfg_q.touch_kind         <= pwdata[0];
				REG_THRESHOLD:  cfg_q.pressure_threshold <= pwdata[PRES_W-1:0];
				REG_LANDSCAPE:  cfg_q.landscape          <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_TOUCH_KIND: prdata[0]          = cfg_q.touch_kind;
			REG_THRESHOLD:  prdata[PRES_W-1:0] = cfg_q.pressure_threshold;
			REG_LANDSCAPE:  prdata[0]          = cfg_q.landscape;
			default:        prdata             = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
